### src/rcfd_pkg.sv
package rcfd_pkg;

  localparam int FRAME_BYTES  = 18;
  localparam int IDX_W        = 5;
  localparam int VAL_W        = 11;
  localparam int SW_W         = 2;
  localparam int NUM_STICKS   = 4;
  localparam int HEAD_BYTES   = 6;   // bytes 0..5 carry sticks and switches
  localparam int WHEEL_LO_POS = 16;  // byte 16 is the wheel low byte
  localparam int LAST_POS     = FRAME_BYTES - 1;

  localparam int CFG_IDX_W    = 3;
  localparam int OUT_DATA_W   = 64;
  localparam int OUT_USED_W   = NUM_STICKS * VAL_W + 2 * SW_W + VAL_W;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_MIN     = 3'd0,
    REG_VALID_MAX     = 3'd1,
    REG_DEADBAND_LOW  = 3'd2,
    REG_DEADBAND_HIGH = 3'd3,
    REG_CENTER_VALUE  = 3'd4
  } cfg_reg_t;

  localparam logic [VAL_W-1:0] RST_VALID_MIN     = 11'd364;
  localparam logic [VAL_W-1:0] RST_VALID_MAX     = 11'd1684;
  localparam logic [VAL_W-1:0] RST_DEADBAND_LOW  = 11'd1020;
  localparam logic [VAL_W-1:0] RST_DEADBAND_HIGH = 11'd1028;
  localparam logic [VAL_W-1:0] RST_CENTER_VALUE  = 11'd1024;
  localparam logic [VAL_W-1:0] RST_HELD_VALUE    = 11'd1024;
  localparam logic [SW_W-1:0]  RST_HELD_SWITCH   = 2'd3;
  localparam logic [SW_W-1:0]  SW_INVALID        = 2'd0;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [SW_W-1:0]  sw_t;
  typedef logic [7:0]       byte_t;

  typedef struct packed {
    val_t valid_min;
    val_t valid_max;
    val_t deadband_low;
    val_t deadband_high;
    val_t center_value;
  } cfg_t;

  // stored frame bytes the decode needs; byte 17 comes straight from the input
  typedef struct packed {
    byte_t [HEAD_BYTES-1:0] head;
    byte_t                  wheel_lo;
  } frame_bytes_t;

  typedef struct packed {
    val_t [NUM_STICKS-1:0] stick;
    sw_t                   switch_left;
    sw_t                   switch_right;
    val_t                  wheel;
    logic                  ok;
  } decode_t;

endpackage

### src/rcfd_cfg_regs.sv
module rcfd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfd_pkg::VAL_W-1:0]      cfg_data,
  output rcfd_pkg::cfg_t                  cfg
);
  import rcfd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // register file write, indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_VALID_MIN:     cfg_nxt.valid_min     = cfg_data;
        REG_VALID_MAX:     cfg_nxt.valid_max     = cfg_data;
        REG_DEADBAND_LOW:  cfg_nxt.deadband_low  = cfg_data;
        REG_DEADBAND_HIGH: cfg_nxt.deadband_high = cfg_data;
        REG_CENTER_VALUE:  cfg_nxt.center_value  = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.valid_min     <= RST_VALID_MIN;
      cfg_r.valid_max     <= RST_VALID_MAX;
      cfg_r.deadband_low  <= RST_DEADBAND_LOW;
      cfg_r.deadband_high <= RST_DEADBAND_HIGH;
      cfg_r.center_value  <= RST_CENTER_VALUE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/rcfd_frame_capture.sv
module rcfd_frame_capture (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    beat,        // input beat accepted
  input  logic [7:0]              rx_byte,
  input  logic                    frame_start,
  output rcfd_pkg::frame_bytes_t  bytes,
  output logic                    last_beat    // this beat is byte 17 of a frame
);
  import rcfd_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] idx_eff;
  logic             in_frame;
  frame_bytes_t     bytes_r;

  // a start flag restarts at byte 0 whatever the current position
  assign idx_eff   = frame_start ? '0 : idx_r;
  assign in_frame  = (idx_eff < IDX_W'(FRAME_BYTES));
  assign last_beat = beat && (idx_eff == IDX_W'(LAST_POS));

  always_comb begin
    idx_nxt = idx_r;
    if (beat && in_frame) begin
      idx_nxt = idx_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_W'(FRAME_BYTES);
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // byte slots, each loaded at its own position
  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (beat && (idx_eff == IDX_W'(i))) begin
        bytes_r.head[i] <= rx_byte;
      end
    end
    if (beat && (idx_eff == IDX_W'(WHEEL_LO_POS))) begin
      bytes_r.wheel_lo <= rx_byte;
    end
  end

  assign bytes = bytes_r;

endmodule

### src/rcfd_decode.sv
module rcfd_decode (
  input  rcfd_pkg::frame_bytes_t  bytes,
  input  logic [7:0]              last_byte,
  input  rcfd_pkg::cfg_t          cfg,
  output rcfd_pkg::decode_t       dec
);
  import rcfd_pkg::*;

  val_t [NUM_STICKS-1:0] raw;
  val_t [NUM_STICKS-1:0] snap;
  logic                  range_ok;

  // little-endian 11-bit unpack
  assign raw[0] = {bytes.head[1][2:0], bytes.head[0]};
  assign raw[1] = {bytes.head[2][5:0], bytes.head[1][7:3]};
  assign raw[2] = {bytes.head[4][0], bytes.head[3], bytes.head[2][7:6]};
  assign raw[3] = {bytes.head[5][3:0], bytes.head[4][7:1]};

  always_comb begin
    range_ok = 1'b1;
    for (int k = 0; k < NUM_STICKS; k++) begin
      if (raw[k] < cfg.valid_min || raw[k] > cfg.valid_max) begin
        range_ok = 1'b0;
      end
    end
  end

  // deadband snap, open window
  always_comb begin
    for (int k = 0; k < NUM_STICKS; k++) begin
      if (raw[k] > cfg.deadband_low && raw[k] < cfg.deadband_high) begin
        snap[k] = cfg.center_value;
      end else begin
        snap[k] = raw[k];
      end
    end
  end

  assign dec.stick        = snap;
  assign dec.switch_left  = bytes.head[5][7:6];
  assign dec.switch_right = bytes.head[5][5:4];
  assign dec.wheel        = {last_byte[2:0], bytes.wheel_lo};
  assign dec.ok           = range_ok && (dec.switch_left != SW_INVALID)
                            && (dec.switch_right != SW_INVALID);

endmodule

### src/remote_control_frame_decoder.sv
// Remote-control frame decoder.
// Input stream: one received frame byte per beat, in_tdata = rx_byte,
// in_tuser = frame_start (marks byte 0 of a frame; restarts a partial frame).
// Bytes outside a frame (after byte 17, or after reset) are dropped.
// On byte 17 the frame is unpacked into four sticks, two switches and the
// wheel, range checked and deadband snapped; the held values update only when
// the frame passes. One result beat per completed frame carries the held
// values, with out_tuser = frame_accepted.
// The result is registered and valid in the cycle after the last byte beat.
// Throughput: one byte per cycle while in_tready is high; decode is a single
// compare/select level between the byte slots and the output register.
// When the receiver stalls, the output register holds its beat and
// in_tready drops until that beat is taken.
// Configuration: cfg_index selects valid_min, valid_max, deadband_low,
// deadband_high, center_value (0..4); cfg_ready is always high.
// Reset (rst_n low, synchronous): registers to defaults, held sticks and
// wheel to 1024, switches to 3, framer idle until a start byte.
module remote_control_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // bits: [7:0] rx_byte
  input  logic [7:0]  in_tdata,
  // bits: [0] frame_start
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bits: [10:0] stick0, [21:11] stick1, [32:22] stick2, [43:33] stick3,
  //       [45:44] switch_left, [47:46] switch_right, [58:48] wheel, [63:59] zero
  output logic [63:0] out_tdata,
  // bits: [0] frame_accepted
  output logic [0:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import rcfd_pkg::*;

  cfg_t         cfg;
  frame_bytes_t bytes;
  decode_t      dec;
  logic         in_beat;
  logic         last_beat;

  val_t [NUM_STICKS-1:0] held_stick_r, held_stick_nxt;
  sw_t                   held_swl_r, held_swl_nxt;
  sw_t                   held_swr_r, held_swr_nxt;
  val_t                  held_wheel_r, held_wheel_nxt;

  logic [OUT_USED_W-1:0] held_packed_nxt;
  logic [OUT_USED_W-1:0] held_packed;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  rcfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcfd_frame_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (in_beat),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser[0]),
    .bytes       (bytes),
    .last_beat   (last_beat)
  );

  rcfd_decode u_decode (
    .bytes     (bytes),
    .last_byte (in_tdata),
    .cfg       (cfg),
    .dec       (dec)
  );

  // held values update on a passing frame only
  always_comb begin
    held_stick_nxt = held_stick_r;
    held_swl_nxt   = held_swl_r;
    held_swr_nxt   = held_swr_r;
    held_wheel_nxt = held_wheel_r;
    if (last_beat && dec.ok) begin
      held_stick_nxt = dec.stick;
      held_swl_nxt   = dec.switch_left;
      held_swr_nxt   = dec.switch_right;
      held_wheel_nxt = dec.wheel;
    end
  end

  assign held_packed_nxt = {held_wheel_nxt, held_swr_nxt, held_swl_nxt,
                            held_stick_nxt[3], held_stick_nxt[2],
                            held_stick_nxt[1], held_stick_nxt[0]};
  assign held_packed     = {held_wheel_r, held_swr_r, held_swl_r,
                            held_stick_r[3], held_stick_r[2],
                            held_stick_r[1], held_stick_r[0]};

  // output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_acc_nxt   = out_acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (last_beat) begin
      out_data_nxt  = OUT_DATA_W'(held_packed_nxt);
      out_acc_nxt   = dec.ok;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        held_stick_r[k] <= RST_HELD_VALUE;
      end
      held_swl_r   <= RST_HELD_SWITCH;
      held_swr_r   <= RST_HELD_SWITCH;
      held_wheel_r <= RST_HELD_VALUE;
      out_valid_r  <= 1'b0;
    end else begin
      held_stick_r <= held_stick_nxt;
      held_swl_r   <= held_swl_nxt;
      held_swr_r   <= held_swr_nxt;
      held_wheel_r <= held_wheel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_acc_r;
  assign out_tvalid   = out_valid_r;

`ifndef NO_ASSERTIONS
  // a pending result always shows the current held values
  a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[OUT_USED_W-1:0] == held_packed))
    else $error("pending result differs from held values");

  // held switches never take the invalid code
  a_held_switch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (held_swl_r != SW_INVALID) && (held_swr_r != SW_INVALID))
    else $error("held switch holds invalid code");

  // only a final frame byte raises a result
  a_result_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !last_beat) |=> !out_valid_r)
    else $error("result raised without a final frame byte");
`endif

endmodule

### verif/rcfd_frame_checker.sv
// Watches the byte, result and register channels of the frame decoder,
// keeps its own framer and held values, and compares every result beat
// against the oldest predicted one.
module rcfd_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_cnt,
  output int          pending_cnt
);
  import rcfd_pkg::*;

  cfg_t        cfg;
  byte_t       rx_bytes [FRAME_BYTES];
  int unsigned byte_pos;
  decode_t     held;
  decode_t     frame_result_q [$];
  int          errors = 0;

  // Framer: store the byte, decode on the last one, queue the result beat
  task automatic take_rx_byte(input byte_t b, input logic start);
    logic [8*FRAME_BYTES-1:0] bits;
    val_t [NUM_STICKS-1:0]    st;
    sw_t                      swl;
    sw_t                      swr;
    logic                     ok;
    decode_t                  res;
    int                       k;
    if (start) byte_pos = 0;
    if (byte_pos < FRAME_BYTES) begin
      rx_bytes[byte_pos] = b;
      byte_pos++;
      if (byte_pos == FRAME_BYTES) begin
        for (k = 0; k < FRAME_BYTES; k++) bits[8*k +: 8] = rx_bytes[k];
        // little-endian bit stream: 11-bit sticks back to back from bit 0
        st[0] = bits[10:0];
        st[1] = bits[21:11];
        st[2] = bits[32:22];
        st[3] = bits[43:33];
        swr   = bits[45:44];
        swl   = bits[47:46];
        ok    = (swl != SW_INVALID) && (swr != SW_INVALID);
        for (k = 0; k < NUM_STICKS; k++)
          if (st[k] < cfg.valid_min || st[k] > cfg.valid_max) ok = 1'b0;
        // held values move only on an accepted frame
        if (ok) begin
          for (k = 0; k < NUM_STICKS; k++)
            held.stick[k] = (st[k] > cfg.deadband_low && st[k] < cfg.deadband_high) ?
                            cfg.center_value : st[k];
          held.switch_left  = swl;
          held.switch_right = swr;
          held.wheel        = bits[8*WHEEL_LO_POS +: VAL_W];
        end
        res    = held;
        res.ok = ok;
        frame_result_q.push_back(res);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [10:0] want_v,
                             input logic [10:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    decode_t want;
    int      k;
    if (!rst_n) begin
      cfg.valid_min     = RST_VALID_MIN;
      cfg.valid_max     = RST_VALID_MAX;
      cfg.deadband_low  = RST_DEADBAND_LOW;
      cfg.deadband_high = RST_DEADBAND_HIGH;
      cfg.center_value  = RST_CENTER_VALUE;
      byte_pos          = FRAME_BYTES;
      for (k = 0; k < NUM_STICKS; k++) held.stick[k] = RST_HELD_VALUE;
      held.switch_left  = RST_HELD_SWITCH;
      held.switch_right = RST_HELD_SWITCH;
      held.wheel        = RST_HELD_VALUE;
      held.ok           = 1'b0;
      frame_result_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (frame_result_q.size() == 0) begin
          $error("result beat with no completed frame pending");
          errors++;
        end else begin
          want = frame_result_q.pop_front();
          check_field("stick0", want.stick[0], out_tdata[10:0]);
          check_field("stick1", want.stick[1], out_tdata[21:11]);
          check_field("stick2", want.stick[2], out_tdata[32:22]);
          check_field("stick3", want.stick[3], out_tdata[43:33]);
          check_field("switch_left", VAL_W'(want.switch_left), VAL_W'(out_tdata[45:44]));
          check_field("switch_right", VAL_W'(want.switch_right), VAL_W'(out_tdata[47:46]));
          check_field("wheel", want.wheel, out_tdata[58:48]);
          check_field("frame_accepted", VAL_W'(want.ok), VAL_W'(out_tuser[0]));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VALID_MIN:     cfg.valid_min     = cfg_data;
          REG_VALID_MAX:     cfg.valid_max     = cfg_data;
          REG_DEADBAND_LOW:  cfg.deadband_low  = cfg_data;
          REG_DEADBAND_HIGH: cfg.deadband_high = cfg_data;
          REG_CENTER_VALUE:  cfg.center_value  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_rx_byte(in_tdata, in_tuser[0]);
    end
    pending_cnt <= frame_result_q.size();
    fail_cnt    <= errors;
  end

endmodule

### verif/remote_control_frame_decoder_tb.sv
// Stimulus and verdict for the frame decoder; checking lives in rcfd_frame_checker.
module remote_control_frame_decoder_tb;
  import rcfd_pkg::*;

  localparam int RAND_BYTES = 760;
  localparam int PHASES     = 6;

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;
  int          fail_cnt;
  int          pending_cnt;

  cfg_t cfg_now;
  bit   tx_steady;
  bit   rx_steady;
  int   frame_bytes_sent;

  remote_control_frame_decoder i_dut (.*);
  rcfd_frame_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("remote_control_frame_decoder_tb failed");
    $finish;
  end

  // Receiver: random stall before each result beat, with steady stretches
  initial begin
    int gap;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // One byte beat; tvalid stays high on return
  task automatic send_rx_byte(input byte_t b, input logic start);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= b;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Pack a frame with random filler and send its first n_bytes bytes
  task automatic send_frame(input val_t s0, input val_t s1, input val_t s2,
                            input val_t s3, input sw_t swl, input sw_t swr,
                            input val_t wh, input int n_bytes);
    logic [8*FRAME_BYTES-1:0] bits;
    int                       k;
    for (k = 0; k < FRAME_BYTES; k++) bits[8*k +: 8] = $urandom_range(0, 255);
    bits[10:0]    = s0;
    bits[21:11]   = s1;
    bits[32:22]   = s2;
    bits[43:33]   = s3;
    bits[45:44]   = swr;
    bits[47:46]   = swl;
    bits[138:128] = wh;
    for (k = 0; k < n_bytes; k++) send_rx_byte(bits[8*k +: 8], k == 0);
    frame_bytes_sent += n_bytes;
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input val_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(input val_t vmin, input val_t vmax, input val_t dlo,
                              input val_t dhi, input val_t ctr);
    write_reg(REG_VALID_MIN, vmin);
    write_reg(REG_VALID_MAX, vmax);
    write_reg(REG_DEADBAND_LOW, dlo);
    write_reg(REG_DEADBAND_HIGH, dhi);
    write_reg(REG_CENTER_VALUE, ctr);
    cfg_valid <= 1'b0;
    cfg_now.valid_min     = vmin;
    cfg_now.valid_max     = vmax;
    cfg_now.deadband_low  = dlo;
    cfg_now.deadband_high = dhi;
    cfg_now.center_value  = ctr;
  endtask

  // Stick values aimed at range and deadband edges; clean avoids the values just past the range
  function automatic val_t pick_stick(input bit clean);
    val_t lo;
    val_t hi;
    lo = cfg_now.valid_min;
    hi = cfg_now.valid_max;
    case ($urandom_range(0, 15))
      0:       return clean ? lo : lo - 11'd1;
      1:       return clean ? hi : hi + 11'd1;
      2:       return lo;
      3:       return hi;
      4:       return cfg_now.deadband_low;
      5:       return cfg_now.deadband_low + 11'd1;
      6:       return cfg_now.deadband_high - 11'd1;
      7:       return cfg_now.deadband_high;
      8:       return cfg_now.center_value;
      default: return (lo <= hi) ? val_t'($urandom_range(lo, hi))
                                 : val_t'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic sw_t pick_switch(input bit clean);
    if (clean || $urandom_range(0, 7) != 0) return sw_t'($urandom_range(1, 3));
    return SW_INVALID;
  endfunction

  initial begin
    int  p;
    int  k;
    int  n;
    bit  clean;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    cfg_now.valid_min     = RST_VALID_MIN;
    cfg_now.valid_max     = RST_VALID_MAX;
    cfg_now.deadband_low  = RST_DEADBAND_LOW;
    cfg_now.deadband_high = RST_DEADBAND_HIGH;
    cfg_now.center_value  = RST_CENTER_VALUE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bytes while idle after reset are dropped
    send_rx_byte(8'hFF, 1'b0);
    send_rx_byte(8'h00, 1'b0);
    // accepted, range edges, deadband snap, rejects on each check
    send_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd2, 11'd0, FRAME_BYTES);
    send_frame(11'd364, 11'd1684, 11'd1021, 11'd1027, 2'd3, 2'd3, 11'd2047, FRAME_BYTES);
    send_frame(11'd363, 11'd1024, 11'd1024, 11'd1024, 2'd2, 2'd1, 11'd5, FRAME_BYTES);
    send_frame(11'd1024, 11'd1024, 11'd1685, 11'd1024, 2'd1, 2'd1, 11'd7, FRAME_BYTES);
    send_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd0, 2'd2, 11'd9, FRAME_BYTES);
    send_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd3, 2'd0, 11'd9, FRAME_BYTES);
    // start mid-frame drops the partial one
    send_frame(11'd500, 11'd600, 11'd700, 11'd800, 2'd1, 2'd1, 11'd0, 7);
    send_frame(11'd1020, 11'd1028, 11'd1019, 11'd1029, 2'd2, 2'd2, 11'd1234, FRAME_BYTES);
    // trailing bytes after a complete frame
    send_rx_byte(8'hA5, 1'b0);
    send_rx_byte(8'h5A, 1'b0);
    wait_idle();
    // inverted valid range with an empty deadband
    apply_config(11'd1500, 11'd500, 11'd1024, 11'd1024, 11'd0);
    send_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd1, 11'd3, FRAME_BYTES);
    wait_idle();
    // full range, adjacent deadband edges
    apply_config(11'd0, 11'd2047, 11'd1024, 11'd1025, 11'd2047);
    send_frame(11'd0, 11'd2047, 11'd1024, 11'd1025, 2'd3, 2'd3, 11'd2047, FRAME_BYTES);
    wait_idle();

    // random phases, one register setting each
    frame_bytes_sent = 0;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(RST_VALID_MIN, RST_VALID_MAX, RST_DEADBAND_LOW,
                        RST_DEADBAND_HIGH, RST_CENTER_VALUE);
        1: apply_config(11'd0, 11'd2047, 11'd0, 11'd2047, 11'd2047);
        2: apply_config(11'd1500, 11'd500, 11'd1028, 11'd1020, 11'd0);
        3: apply_config(11'd1000, 11'd1050, 11'd1023, 11'd1025, 11'd5);
        4: apply_config(val_t'($urandom_range(0, 1024)), val_t'($urandom_range(1024, 2047)),
                        val_t'($urandom_range(900, 1100)), val_t'($urandom_range(950, 1200)),
                        val_t'($urandom_range(0, 2047)));
        default: apply_config(val_t'($urandom_range(0, 2047)), val_t'($urandom_range(0, 2047)),
                              val_t'($urandom_range(0, 2047)), val_t'($urandom_range(0, 2047)),
                              val_t'($urandom_range(0, 2047)));
      endcase
      while (frame_bytes_sent < (p + 1) * RAND_BYTES / PHASES) begin
        clean = $urandom_range(0, 1);
        case ($urandom_range(0, 19))
          // noise without a start flag
          0: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) send_rx_byte(byte_t'($urandom_range(0, 255)), 1'b0);
          end
          // broken frame, cut short
          1, 2: send_frame(pick_stick(clean), pick_stick(clean), pick_stick(clean),
                           pick_stick(clean), pick_switch(clean), pick_switch(clean),
                           val_t'($urandom_range(0, 2047)), $urandom_range(1, LAST_POS));
          // full frame followed by ignored bytes
          3: begin
            send_frame(pick_stick(clean), pick_stick(clean), pick_stick(clean),
                       pick_stick(clean), pick_switch(clean), pick_switch(clean),
                       val_t'($urandom_range(0, 2047)), FRAME_BYTES);
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) send_rx_byte(byte_t'($urandom_range(0, 255)), 1'b0);
          end
          default: send_frame(pick_stick(clean), pick_stick(clean), pick_stick(clean),
                              pick_stick(clean), pick_switch(clean), pick_switch(clean),
                              val_t'($urandom_range(0, 2047)), FRAME_BYTES);
        endcase
      end
      wait_idle();
    end

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("remote_control_frame_decoder_tb passed");
    end else begin
      $display("remote_control_frame_decoder_tb failed");
    end
    $finish;
  end

endmodule
